@@ rtl/lbp_pkg.sv @@
// Shared types, constants and code tables for the 3x3 LBP code mapper.
// No dependencies; used by lbp_3x3_code_mapper_top.
`default_nettype none

package lbp_pkg;

  // Configuration port
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_CODE_MODE    = 2'd2,
    REG_UNUSED       = 2'd3
  } cfg_reg_t;

  // Register widths and reset values
  localparam int WIDTH_W  = 12;
  localparam int HEIGHT_W = 13;
  localparam int ROW_W    = 12;
  localparam int MODE_W   = 2;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd480;

  typedef enum logic [MODE_W-1:0] {
    MODE_RAW      = 2'd0,
    MODE_UNIFORM  = 2'd1,
    MODE_ROTATION = 2'd2,
    MODE_SPARE    = 2'd3
  } code_mode_t;

  localparam code_mode_t MODE_RST = MODE_ROTATION;

  // Frame geometry limits
  localparam int MIN_DIM          = 3;
  localparam int MAX_ROWS         = 4096;
  localparam int MAX_LINE_PIXELS  = 2048;

  // Pixel / code widths
  localparam int PIX_W  = 8;
  localparam int CODE_W = 8;
  localparam int BIN_W  = 6;
  localparam int NOISE_BIN = 58;

  // Output queue depth: one for the register in view, one in flight, one spare
  localparam int OUT_DEPTH = 3;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              frame_end;
  } lbp_result_t;

  // Uniform bin per raw code, packed 6 bits per entry (elaboration only)
  function automatic logic [256*BIN_W-1:0] build_uniform_rom();
    logic [256*BIN_W-1:0] rom;
    int next;
    int trans;
    rom  = '0;
    next = 0;
    for (int v = 0; v < 256; v++) begin
      trans = 0;
      for (int k = 0; k < 8; k++) begin
        if (((v >> k) & 1) != ((v >> ((k + 1) & 7)) & 1)) trans++;
      end
      if (trans <= 2) begin
        rom[v*BIN_W +: BIN_W] = BIN_W'(next);
        next++;
      end else begin
        rom[v*BIN_W +: BIN_W] = BIN_W'(NOISE_BIN);
      end
    end
    return rom;
  endfunction

  // Rotation-invariant bin per raw code; bins numbered by first minimal rotation
  function automatic logic [256*BIN_W-1:0] build_rotation_rom();
    logic [256*BIN_W-1:0] rom;
    logic [255:0]         seen;
    logic [256*BIN_W-1:0] bin_of;
    int next;
    int r;
    int mn;
    rom    = '0;
    seen   = '0;
    bin_of = '0;
    next   = 0;
    for (int v = 0; v < 256; v++) begin
      r  = v;
      mn = v;
      for (int k = 1; k < 8; k++) begin
        r = ((r << 1) | (r >> 7)) & 255;
        if (r < mn) mn = r;
      end
      if (!seen[mn]) begin
        seen[mn] = 1'b1;
        bin_of[mn*BIN_W +: BIN_W] = BIN_W'(next);
        next++;
      end
      rom[v*BIN_W +: BIN_W] = bin_of[mn*BIN_W +: BIN_W];
    end
    return rom;
  endfunction

  localparam logic [256*BIN_W-1:0] UNIFORM_ROM  = build_uniform_rom();
  localparam logic [256*BIN_W-1:0] ROTATION_ROM = build_rotation_rom();

endpackage

`default_nettype wire

@@ rtl/lbp_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module lbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/lbp_3x3_code_mapper_top.sv @@
// 3x3 local binary pattern code mapper, top level.
// A result goes through the stage 1 registers and the output queue before it is offered.
// Throughput: one pixel per cycle while in_stall is low, set by the single read and
// write port of each line buffer RAM (read at accept, write back in the next cycle).
// Reset (rst_n low, synchronous): counters, window, queue and registers return to
// defaults; line buffers are not cleared and hold garbage until the first two rows pass.
// Depends on lbp_pkg and lbp_ram.
`default_nettype none

module lbp_3x3_code_mapper_top #(
  parameter int MAX_LINE_PIXELS = lbp_pkg::MAX_LINE_PIXELS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration
  input  wire logic                              cfg_we,
  input  wire logic [lbp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lbp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // pixel input
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [lbp_pkg::PIX_W-1:0]         in_pixel_value,
  // code output
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [lbp_pkg::CODE_W-1:0]        out_pattern_code,
  output logic                                   out_frame_end
);

  localparam int CW   = $clog2(MAX_LINE_PIXELS);
  localparam int WLOG = $clog2(MAX_LINE_PIXELS + 1);
  localparam int WCMP = (WLOG > lbp_pkg::WIDTH_W) ? WLOG : lbp_pkg::WIDTH_W;
  localparam int PW   = lbp_pkg::PIX_W;
  localparam int HW   = lbp_pkg::HEIGHT_W;
  localparam int RW   = lbp_pkg::ROW_W;
  localparam int QD   = lbp_pkg::OUT_DEPTH;
  localparam int QAW  = $clog2(QD);
  localparam int QCW  = $clog2(QD + 1);

  // Configuration registers
  logic [lbp_pkg::WIDTH_W-1:0]  cfg_width_r;
  logic [HW-1:0]                cfg_height_r;
  lbp_pkg::code_mode_t          cfg_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= lbp_pkg::WIDTH_RST;
      cfg_height_r <= lbp_pkg::HEIGHT_RST;
      cfg_mode_r   <= lbp_pkg::MODE_RST;
    end else if (cfg_we) begin
      unique case (lbp_pkg::cfg_reg_t'(cfg_index))
        lbp_pkg::REG_IMAGE_WIDTH:  cfg_width_r  <= cfg_wdata[lbp_pkg::WIDTH_W-1:0];
        lbp_pkg::REG_IMAGE_HEIGHT: cfg_height_r <= cfg_wdata[HW-1:0];
        lbp_pkg::REG_CODE_MODE:
          cfg_mode_r <= lbp_pkg::code_mode_t'(cfg_wdata[lbp_pkg::MODE_W-1:0]);
        default: ;
      endcase
    end
  end

  // Clamped geometry: last column and last row indexes
  logic [WCMP-1:0] width_ext;
  logic [WCMP-1:0] width_eff;
  logic [WCMP-1:0] last_col;
  logic [HW-1:0]   height_eff;
  logic [HW-1:0]   last_row;

  always_comb begin
    width_ext = WCMP'(cfg_width_r);
    if (width_ext < WCMP'(lbp_pkg::MIN_DIM)) begin
      width_eff = WCMP'(lbp_pkg::MIN_DIM);
    end else if (width_ext > WCMP'(MAX_LINE_PIXELS)) begin
      width_eff = WCMP'(MAX_LINE_PIXELS);
    end else begin
      width_eff = width_ext;
    end
    last_col = width_eff - WCMP'(1);

    if (cfg_height_r < HW'(lbp_pkg::MIN_DIM)) begin
      height_eff = HW'(lbp_pkg::MIN_DIM);
    end else if (cfg_height_r > HW'(lbp_pkg::MAX_ROWS)) begin
      height_eff = HW'(lbp_pkg::MAX_ROWS);
    end else begin
      height_eff = cfg_height_r;
    end
    last_row = height_eff - HW'(1);
  end

  // Handshake and stage-0 control
  logic            in_accept;
  logic [CW-1:0]   col_r, col_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic            row_end;
  logic            frame_last;
  logic            interior;

  logic            s1_busy_r;
  logic            s1_res_r;
  logic            s1_last_r;
  logic [CW-1:0]   s1_col_r;
  logic [PW-1:0]   s1_pix_r;

  logic [QCW-1:0]  q_cnt_r, q_cnt_nxt;

  // Stall when the queue could not take this pixel's result
  assign in_stall  = (QCW'(q_cnt_r) + QCW'(s1_res_r)) >= QCW'(QD);
  assign in_accept = in_valid && !in_stall;

  assign row_end    = WCMP'(col_r) >= last_col;
  assign frame_last = row_end && (HW'(row_r) >= last_row);
  assign interior   = (row_r >= RW'(2)) && (col_r >= CW'(2));

  // Raster counters
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_accept) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_last ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Stage 1 registers: pixel waits for the line buffer read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_busy_r <= 1'b0;
      s1_res_r  <= 1'b0;
    end else begin
      s1_busy_r <= in_accept;
      s1_res_r  <= in_accept && interior;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_col_r  <= col_r;
      s1_pix_r  <= in_pixel_value;
      s1_last_r <= frame_last;
    end
  end

  // Line buffers: read at accept, write back in the next cycle.
  // Consecutive pixels never share a column, so no forwarding is needed.
  logic [PW-1:0] mid_rd;
  logic [PW-1:0] top_rd;

  lbp_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_LINE_PIXELS)
  ) u_row_above (
    .clk   (clk),
    .we    (s1_busy_r),
    .waddr (s1_col_r),
    .wdata (s1_pix_r),
    .raddr (col_r),
    .rdata (mid_rd)
  );

  lbp_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_LINE_PIXELS)
  ) u_two_rows_above (
    .clk   (clk),
    .we    (s1_busy_r),
    .waddr (s1_col_r),
    .wdata (mid_rd),
    .raddr (col_r),
    .rdata (top_rd)
  );

  // Window: entries 0..2 column c-2 (top, mid, bottom), 3..5 column c-1
  logic [PW-1:0] win_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else if (s1_busy_r) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top_rd;
      win_r[4] <= mid_rd;
      win_r[5] <= s1_pix_r;
    end
  end

  // Code: neighbor strictly above center, weights clockwise from top-left
  logic [PW-1:0]              ctr;
  logic [lbp_pkg::CODE_W-1:0] raw_code;
  logic [lbp_pkg::CODE_W-1:0] mapped_code;

  always_comb begin
    ctr         = win_r[4];
    raw_code[0] = win_r[0] > ctr;
    raw_code[1] = win_r[3] > ctr;
    raw_code[2] = top_rd   > ctr;
    raw_code[3] = mid_rd   > ctr;
    raw_code[4] = s1_pix_r > ctr;
    raw_code[5] = win_r[5] > ctr;
    raw_code[6] = win_r[2] > ctr;
    raw_code[7] = win_r[1] > ctr;

    case (cfg_mode_r)
      lbp_pkg::MODE_UNIFORM:
        mapped_code = lbp_pkg::CODE_W'(
          lbp_pkg::UNIFORM_ROM[raw_code*lbp_pkg::BIN_W +: lbp_pkg::BIN_W]);
      lbp_pkg::MODE_ROTATION:
        mapped_code = lbp_pkg::CODE_W'(
          lbp_pkg::ROTATION_ROM[raw_code*lbp_pkg::BIN_W +: lbp_pkg::BIN_W]);
      default:
        mapped_code = raw_code;
    endcase
  end

  // Output queue
  lbp_pkg::lbp_result_t q_mem_r [QD];
  logic [QAW-1:0]       q_wr_r, q_rd_r;
  logic                 q_push, q_pop;
  lbp_pkg::lbp_result_t q_head;

  assign q_push = s1_res_r;
  assign q_pop  = out_valid && !out_stall;

  always_comb begin
    q_cnt_nxt = q_cnt_r;
    if (q_push && !q_pop) begin
      q_cnt_nxt = q_cnt_r + QCW'(1);
    end else if (q_pop && !q_push) begin
      q_cnt_nxt = q_cnt_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
      if (q_push) begin
        q_wr_r <= (q_wr_r == QAW'(QD - 1)) ? '0 : q_wr_r + QAW'(1);
      end
      if (q_pop) begin
        q_rd_r <= (q_rd_r == QAW'(QD - 1)) ? '0 : q_rd_r + QAW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem_r[q_wr_r] <= '{code: mapped_code, frame_end: s1_last_r};
    end
  end

  assign q_head           = q_mem_r[q_rd_r];
  assign out_valid        = q_cnt_r != '0;
  assign out_pattern_code = q_head.code;
  assign out_frame_end    = q_head.frame_end;

  // Assertions

  // A result reaching the queue always finds a free slot
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    s1_res_r |-> (q_cnt_r < QCW'(QD)))
    else $error("result pushed into full output queue");

  // Write-back and next read never hit the same line buffer column
  a_no_col_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_busy_r && in_accept) |-> (s1_col_r != col_r))
    else $error("line buffer read and write collide on one column");

  // End of row returns the column counter to zero
  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && row_end) |=> (col_r == '0))
    else $error("column counter did not wrap at row end");

  // Frame end marker implies the row counter was reset
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && frame_last) |=> (row_r == '0))
    else $error("row counter did not wrap at frame end");

endmodule

`default_nettype wire
